### rtl/note_off_scheduler_defines.svh
// Assertion macros for the note-off scheduler.
`ifndef NOTE_OFF_SCHEDULER_DEFINES_SVH
`define NOTE_OFF_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NOS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nos_pkg.sv
// Types, constants and helpers shared by the note-off scheduler modules.
package nos_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int CHAN_W      = 5;
    localparam int DUR_W       = 16;
    localparam int TIME_W      = 32;
    localparam int PCNT_W      = 5;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 32;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    typedef enum logic {
        CMD_PLAY = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic {
        EV_NOTE_ON  = 1'b0,
        EV_NOTE_OFF = 1'b1
    } event_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] deadline;
        logic              expired;
    } entry_t;

    typedef struct packed {
        logic              play;
        logic              arm;
        logic              step;
        logic              keep;
        logic [CNT_W-1:0]  cnt;
        entry_t            new_ent;
        logic [TIME_W-1:0] now_inc;
    } cell_ctl_t;

    function automatic logic [PCNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        if (32'(c) > 32'd31) begin
            return 5'd31;
        end
        return PCNT_W'(c);
    endfunction

endpackage

### rtl/nos_cell.sv
// One table slot: holds an entry, retargets, arms and shifts it along the row.
module nos_cell (
    input  logic                      aclk,
    input  nos_pkg::cell_ctl_t        ctl,
    input  logic [nos_pkg::CNT_W-1:0] idx,
    input  nos_pkg::entry_t           nb,
    input  nos_pkg::entry_t           head,
    output nos_pkg::entry_t           q
);
    import nos_pkg::*;

    entry_t         ent_reg;
    entry_t         ent_next;
    logic [CNT_W:0] idx_inc;
    logic [CNT_W:0] cnt_ext;

    assign idx_inc = {1'b0, idx} + 1'b1;
    assign cnt_ext = {1'b0, ctl.cnt};

    always_comb begin
        ent_next = ent_reg;
        if (ctl.play) begin
            if (idx < ctl.cnt && ent_reg.note == ctl.new_ent.note) begin
                ent_next.deadline = ctl.new_ent.deadline;
            end
            if (idx == ctl.cnt) begin
                ent_next = ctl.new_ent;
            end
        end else if (ctl.arm) begin
            ent_next.expired = (ent_reg.deadline <= ctl.now_inc);
        end else if (ctl.step) begin
            if (idx_inc < cnt_ext) begin
                ent_next = nb;
            end else if (idx_inc == cnt_ext && ctl.keep) begin
                // survivor goes to the back of the occupied region
                ent_next         = head;
                ent_next.expired = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign q = ent_reg;

endmodule

### rtl/note_off_scheduler.sv
// Top level of the note-off scheduler: control, output register and the row of cells.
//
//  channel | dir | content
//  s_      | in  | tuser: command; tdata: note, velocity, channel, duration_ms
//  m_      | out | tuser: event_kind; tdata: note, velocity, channel, dropped,
//          |     | playing_count; tlast: final item of the input
//
// A play item yields its note-on in the output register in the cycle after it is accepted.
// A tick first arms every cell's deadline compare, then rotates the row through
// the head cell once per stored entry, and then returns to idle.
// Each due entry leaving the head waits for the output register; survivors do not.
// Reset empties the table and clears the millisecond counter; no clearing pass.
`include "note_off_scheduler_defines.svh"

module note_off_scheduler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [6:0] note_number, [13:7] note_velocity, [18:14] note_channel, [34:19] duration_ms
    input  logic [nos_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] command
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] out_note, [13:7] out_velocity, [18:14] out_channel, [19] dropped,
    // [24:20] playing_count
    output logic [nos_pkg::M_DATA_W-1:0]    m_tdata,
    // [0] event_kind
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import nos_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    logic [RES_W-1:0]  nres_reg;
    logic [RES_W-1:0]  nres_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;

    logic              m_tvalid_reg;
    logic              m_tlast_reg;
    event_t            m_kind_reg;
    logic [NOTE_W-1:0] m_note_reg;
    logic [VEL_W-1:0]  m_vel_reg;
    logic [CHAN_W-1:0] m_chan_reg;
    logic              m_drop_reg;
    logic [PCNT_W-1:0] m_pcnt_reg;

    logic              out_free;
    logic              in_acc;
    logic              play_acc;
    logic              tick_acc;
    logic              sweeping;
    logic              head_due;
    logic              emit;
    logic              step_go;
    logic              any_more;
    logic              table_full;
    logic [TIME_W-1:0] now_inc;
    logic [CNT_W-1:0]  cnt_play;

    cell_ctl_t         ctl;
    entry_t            q   [TABLE_DEPTH];
    entry_t            nb  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] more_vec;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign in_acc     = s_tvalid && s_tready;
    assign play_acc   = in_acc && (cmd_t'(s_tuser) == CMD_PLAY);
    assign tick_acc   = in_acc && (cmd_t'(s_tuser) == CMD_TICK);
    assign sweeping   = (state_reg == ST_SWEEP) && (step_reg != '0);
    assign head_due   = q[0].expired && (nres_reg < RES_W'(MAX_RESULTS));
    assign emit       = sweeping && head_due && out_free;
    assign step_go    = sweeping && (!head_due || out_free);
    assign table_full = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign now_inc    = now_reg + 1'b1;
    assign cnt_play   = table_full ? cnt_reg : cnt_reg + 1'b1;

    always_comb begin
        ctl                  = '0;
        ctl.play             = play_acc;
        ctl.arm              = tick_acc;
        ctl.step             = step_go;
        ctl.keep             = !head_due;
        ctl.cnt              = cnt_reg;
        ctl.new_ent.note     = s_tdata[6:0];
        ctl.new_ent.velocity = s_tdata[13:7];
        ctl.new_ent.channel  = s_tdata[18:14];
        ctl.new_ent.deadline = now_reg + TIME_W'(s_tdata[34:19]);
        ctl.new_ent.expired  = 1'b0;
        ctl.now_inc          = now_inc;
    end

    // row of cells; cell 0 is the head, each occupied cell below the last takes its upper neighbour on a step
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i < TABLE_DEPTH - 1) begin : g_mid
            assign nb[i] = q[i+1];
        end else begin : g_end
            assign nb[i] = q[0];
        end

        if (i == 0) begin : g_head
            assign more_vec[i] = 1'b0;
        end else begin : g_rest
            assign more_vec[i] = (CNT_W'(i) < cnt_reg) && q[i].expired;
        end

        nos_cell u_cell (
            .aclk (aclk),
            .ctl  (ctl),
            .idx  (CNT_W'(i)),
            .nb   (nb[i]),
            .head (q[0]),
            .q    (q[i])
        );
    end

    assign any_more = |more_vec;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        nres_next  = nres_reg;
        now_next   = now_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (play_acc) begin
                    cnt_next = cnt_play;
                end else if (tick_acc) begin
                    now_next   = now_inc;
                    step_next  = cnt_reg;
                    nres_next  = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (step_reg == '0) begin
                    state_next = ST_IDLE;
                end
                if (step_go) begin
                    step_next = step_reg - 1'b1;
                end
                if (emit) begin
                    cnt_next  = cnt_reg - 1'b1;
                    nres_next = nres_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            nres_reg  <= '0;
            now_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            nres_reg  <= nres_next;
            now_reg   <= now_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= play_acc || emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (play_acc) begin
                m_kind_reg  <= EV_NOTE_ON;
                m_note_reg  <= s_tdata[6:0];
                m_vel_reg   <= s_tdata[13:7];
                m_chan_reg  <= s_tdata[18:14];
                m_drop_reg  <= table_full;
                m_pcnt_reg  <= sat_count(cnt_play);
                m_tlast_reg <= 1'b1;
            end else if (emit) begin
                m_kind_reg  <= EV_NOTE_OFF;
                m_note_reg  <= q[0].note;
                m_vel_reg   <= q[0].velocity;
                m_chan_reg  <= q[0].channel;
                m_drop_reg  <= 1'b0;
                m_pcnt_reg  <= sat_count(cnt_reg - 1'b1);
                m_tlast_reg <= !any_more || (nres_reg == RES_W'(MAX_RESULTS - 1));
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(M_DATA_W - 25){1'b0}}, m_pcnt_reg, m_drop_reg,
                       m_chan_reg, m_vel_reg, m_note_reg};

    `NOS_ASSERT_NOW(a_cnt_bound, state_reg == ST_IDLE, cnt_reg <= CNT_W'(TABLE_DEPTH), "table count above depth")
    `NOS_ASSERT_NEXT(a_play_fill, play_acc && !table_full, cnt_reg == $past(cnt_reg) + 1'b1, "play did not store its entry")
    `NOS_ASSERT_NEXT(a_play_out, play_acc, m_tvalid_reg && m_tlast_reg && m_kind_reg == EV_NOTE_ON, "play gave no final note-on")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the note-off scheduler: directed table, then random traffic.
module tb_top;
    import nos_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 22;

    typedef struct packed {
        event_t             kind;
        logic [NOTE_W-1:0]  note;
        logic [VEL_W-1:0]   vel;
        logic [CHAN_W-1:0]  chan;
        logic               drop;
        logic [PCNT_W-1:0]  count;
        logic               last;
    } midi_event_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [S_DATA_W-1:0]   data;
        logic                  typed;
        midi_event_t           want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // travels with the item so the monitor knows whether a hand-typed event applies
    logic                  item_typed = 1'b0;
    midi_event_t           item_want = '0;

    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    fails = 0;
    int                    quiet = 0;

    // scheduler mirror
    logic [NOTE_W-1:0]     slot_note [TABLE_DEPTH];
    logic [VEL_W-1:0]      slot_vel [TABLE_DEPTH];
    logic [CHAN_W-1:0]     slot_chan [TABLE_DEPTH];
    logic [TIME_W-1:0]     slot_due [TABLE_DEPTH];
    int                    occupancy = 0;
    logic [TIME_W-1:0]     clock_ms = '0;
    midi_event_t           step_events[$];
    midi_event_t           outgoing[$];

    stim_row_t             script[$];

    always #5 aclk = ~aclk;

    note_off_scheduler uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic midi_event_t note_on(int n, int v, int ch, int drop, int cnt);
        midi_event_t ev;
        ev.kind  = EV_NOTE_ON;
        ev.note  = NOTE_W'(n);
        ev.vel   = VEL_W'(v);
        ev.chan  = CHAN_W'(ch);
        ev.drop  = drop[0];
        ev.count = PCNT_W'(cnt);
        ev.last  = 1'b1;
        return ev;
    endfunction

    function automatic stim_row_t make_row(cmd_t c, int n, int v, int ch, int d,
                                           logic typed, midi_event_t want);
        stim_row_t r;
        r.cmd   = c;
        r.data  = S_DATA_W'({DUR_W'(d), CHAN_W'(ch), VEL_W'(v), NOTE_W'(n)});
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // play: retime same-note entries, append or drop; tick: release everything due
    function automatic void schedule_item(cmd_t c, logic [S_DATA_W-1:0] d);
        logic [NOTE_W-1:0] n;
        logic [VEL_W-1:0]  v;
        logic [CHAN_W-1:0] ch;
        logic [DUR_W-1:0]  dur;
        logic [TIME_W-1:0] due;
        midi_event_t       ev;
        int                i;
        int                w;
        int                live;
        int                sent;
        n   = d[6:0];
        v   = d[13:7];
        ch  = d[18:14];
        dur = d[34:19];
        step_events.delete();
        if (c == CMD_PLAY) begin
            due = clock_ms + TIME_W'(dur);
            for (i = 0; i < occupancy; i++) begin
                if (slot_note[i] == n) begin
                    slot_due[i] = due;
                end
            end
            ev.drop = 1'b1;
            if (occupancy < TABLE_DEPTH) begin
                slot_note[occupancy] = n;
                slot_vel[occupancy]  = v;
                slot_chan[occupancy] = ch;
                slot_due[occupancy]  = due;
                occupancy++;
                ev.drop = 1'b0;
            end
            ev.kind  = EV_NOTE_ON;
            ev.note  = n;
            ev.vel   = v;
            ev.chan  = ch;
            ev.count = PCNT_W'(occupancy);
            ev.last  = 1'b1;
            step_events = {step_events, ev};
        end else begin
            clock_ms = clock_ms + 1;
            live = occupancy;
            w = 0;
            sent = 0;
            for (i = 0; i < occupancy; i++) begin
                if (slot_due[i] <= clock_ms && sent < MAX_RESULTS) begin
                    live--;
                    ev.kind  = EV_NOTE_OFF;
                    ev.note  = slot_note[i];
                    ev.vel   = slot_vel[i];
                    ev.chan  = slot_chan[i];
                    ev.drop  = 1'b0;
                    ev.count = PCNT_W'(live);
                    ev.last  = 1'b0;
                    step_events = {step_events, ev};
                    sent++;
                end else begin
                    slot_note[w] = slot_note[i];
                    slot_vel[w]  = slot_vel[i];
                    slot_chan[w] = slot_chan[i];
                    slot_due[w]  = slot_due[i];
                    w++;
                end
            end
            occupancy = w;
            if (sent > 0) begin
                step_events[sent - 1].last = 1'b1;
            end
        end
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        midi_event_t got;
        midi_event_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind  = event_t'(m_tuser);
                got.note  = m_tdata[6:0];
                got.vel   = m_tdata[13:7];
                got.chan  = m_tdata[18:14];
                got.drop  = m_tdata[19];
                got.count = m_tdata[24:20];
                got.last  = m_tlast;
                if (outgoing.size() == 0) begin
                    $display("%0t: unexpected event expected none got kind %0d note %0d",
                             $time, got.kind, got.note);
                    fails++;
                end else begin
                    want = outgoing.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(got.kind));
                    check_field("out_note", 32'(want.note), 32'(got.note));
                    check_field("out_velocity", 32'(want.vel), 32'(got.vel));
                    check_field("out_channel", 32'(want.chan), 32'(got.chan));
                    check_field("dropped", 32'(want.drop), 32'(got.drop));
                    check_field("playing_count", 32'(want.count), 32'(got.count));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
            if (s_tvalid && s_tready) begin
                schedule_item(cmd_t'(s_tuser), s_tdata);
                if (item_typed) begin
                    outgoing = {outgoing, item_want};
                end else begin
                    foreach (step_events[i]) begin
                        outgoing = {outgoing, step_events[i]};
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("note_off_scheduler verification failed");
            $finish;
        end
    end

    task automatic send_row(stim_row_t r);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) begin
                @(posedge aclk);
            end
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= r.cmd;
        s_tdata    <= r.data;
        item_typed <= r.typed;
        item_want  <= r.want;
        @(posedge aclk);
        while (!(s_tvalid && s_tready)) begin
            @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outgoing.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        int          i;
        int          ph;
        int          sel;
        int          n;
        int          d;
        cmd_t        c;
        int          idle_by_phase[4];
        int          stall_by_phase[4];
        idle_by_phase  = '{0, 73, 0, 15};
        stall_by_phase = '{0, 0, 73, 15};

        script = {script, make_row(CMD_TICK, 0, 0, 0, 0, 1'b0, '0)};
        script = {script, make_row(CMD_PLAY, 0, 0, 0, 0, 1'b1, note_on(0, 0, 0, 0, 1))};
        script = {script, make_row(CMD_PLAY, 127, 127, 31, 65535, 1'b1,
                                   note_on(127, 127, 31, 0, 2))};
        script = {script, make_row(CMD_TICK, 0, 0, 0, 0, 1'b0, '0)};
        // fill the table, with repeated notes
        for (i = 0; i < 15; i++) begin
            script = {script, make_row(CMD_PLAY, 40 + i % 5, 10 + i, 1 + i, 3, 1'b0, '0)};
        end
        // full table: dropped, but the old 127 entry is still retimed
        script = {script, make_row(CMD_PLAY, 127, 5, 16, 3, 1'b1,
                                   note_on(127, 5, 16, 1, 16))};
        for (i = 0; i < 3; i++) begin
            script = {script, make_row(CMD_TICK, 0, 0, 0, 0, 1'b0, '0)};
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[k]) begin
            send_row(script[k]);
        end
        drain();

        for (ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                c = ($urandom_range(99) < 40) ? CMD_TICK : CMD_PLAY;
                n = ($urandom_range(9) < 6) ? $urandom_range(63, 60) : $urandom_range(127);
                sel = $urandom_range(9);
                if (sel < 7) begin
                    d = $urandom_range(15);
                end else if (sel < 9) begin
                    d = $urandom_range(300, 16);
                end else begin
                    d = $urandom_range(65535);
                end
                send_row(make_row(c, n, $urandom_range(127), $urandom_range(31), d,
                                  1'b0, '0));
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (outgoing.size() != 0) begin
            $display("%0t: %0d events expected but never seen", $time, outgoing.size());
            fails++;
        end
        if (fails == 0) begin
            $display("note_off_scheduler verification clean");
        end else begin
            $display("note_off_scheduler verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/nos_pkg.sv
rtl/nos_cell.sv
rtl/note_off_scheduler.sv
tb/tb_top.sv
